// ===== hw/rtl/sms_pkg.sv =====
// Shared types and constants for the substring match stream core.
package sms_pkg;

    localparam int MAX_PATTERN_DEF = 16;
    localparam int POS_W           = 32;
    localparam int CNT_W           = 32;
    localparam int LEN_W           = 5;
    localparam int CFG_DATA_W      = 64;
    localparam int CFG_IDX_W       = 2;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_PAT_LO  = 2'd0,
        CFG_PAT_HI  = 2'd1,
        CFG_PAT_LEN = 2'd2
    } t_cfg_idx;

    typedef struct packed {
        logic             found;
        logic [POS_W-1:0] start;
        logic [CNT_W-1:0] count;
        logic             eot;
    } t_result;

endpackage

// ===== hw/rtl/substring_match_stream_core.sv =====
// Top level of the streaming substring match core.
//
// Text bytes enter on the s_axis channel, one byte per transfer, tlast marking
// the final byte of a text. A result leaves on m_axis whenever the configured
// pattern ends at the byte just taken, or the byte is final: tuser flags a
// match, tdata carries the start position and the running match count, and
// tlast marks the result of the final byte. Bytes without a result give no
// transfer. Overlapping matches are all reported.
// The pattern (up to MAX_PATTERN bytes) and its length are written through
// the cfg channel, which is always ready; write it only while the core is idle.
// One byte per cycle while the queue has room: the window compare covers all
// positions in parallel. Results pass through the queue, then the output register.
// When m_axis stalls, results collect in a two-entry queue plus the output
// register; once the queue is full s_axis_tready drops until room is made.
// Reset (synchronous, active low) clears the pattern to zero, its length to
// one, and the position, fill and match count. After a final byte the
// position, fill and count return to zero; the pattern is kept.
module substring_match_stream_core #(
    parameter int MAX_PATTERN = sms_pkg::MAX_PATTERN_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [sms_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [sms_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    input  logic [7:0]                     s_axis_tdata,  // [7:0] text_byte
    input  logic                           s_axis_tlast,  // final_byte
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    output logic [63:0]                    m_axis_tdata,  // [31:0] match_start, [63:32] matches_so_far
    output logic                           m_axis_tuser,  // match_found
    output logic                           m_axis_tlast   // end_of_text
);
    import sms_pkg::*;

    logic    push;
    logic    q_full;
    logic    q_valid;
    logic    pop;
    t_result front_res;
    t_result q_res;
    t_result out_res;

    assign o_cfg_ready = 1'b1;

    sms_front #(
        .MAX_PATTERN (MAX_PATTERN)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_valid     (s_axis_tvalid),
        .o_ready     (s_axis_tready),
        .i_byte      (s_axis_tdata),
        .i_last      (s_axis_tlast),
        .i_q_full    (q_full),
        .o_push      (push),
        .o_result    (front_res)
    );

    sms_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (front_res),
        .o_full  (q_full),
        .o_valid (q_valid),
        .i_pop   (pop),
        .o_data  (q_res)
    );

    sms_out u_out (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (q_valid),
        .i_data  (q_res),
        .o_pop   (pop),
        .o_valid (m_axis_tvalid),
        .i_ready (m_axis_tready),
        .o_data  (out_res)
    );

    assign m_axis_tdata = {out_res.count, out_res.start};
    assign m_axis_tuser = out_res.found;
    assign m_axis_tlast = out_res.eot;

endmodule

// ===== hw/rtl/sms_front.sv =====
// Front end: pattern registers, byte window, parallel compare and result generation.
module sms_front #(
    parameter int MAX_PATTERN = sms_pkg::MAX_PATTERN_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_valid,
    input  logic [sms_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [sms_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  logic                           i_valid,
    output logic                           o_ready,
    input  logic [7:0]                     i_byte,
    input  logic                           i_last,
    input  logic                           i_q_full,
    output logic                           o_push,
    output sms_pkg::t_result               o_result
);
    import sms_pkg::*;

    localparam int FW = $clog2(MAX_PATTERN + 1);

    logic [7:0]            r_win [MAX_PATTERN];
    logic [7:0]            n_win [MAX_PATTERN];
    logic [FW-1:0]         r_fill;
    logic [FW-1:0]         n_fill;
    logic [POS_W-1:0]      r_pos;
    logic [CNT_W-1:0]      r_cnt;
    logic [CNT_W-1:0]      n_cnt;
    logic [CFG_DATA_W-1:0] r_pat_lo;
    logic [CFG_DATA_W-1:0] r_pat_hi;
    logic [LEN_W-1:0]      r_len;

    logic [2*CFG_DATA_W-1:0] pat;
    logic [LEN_W-1:0]        len_eff;
    logic                    mism;
    logic                    found;
    logic [POS_W-1:0]        start;
    logic                    accept;

    always_comb begin
        pat = {r_pat_hi, r_pat_lo};
        if (r_len == '0) begin
            len_eff = LEN_W'(1);
        end else if (r_len > LEN_W'(MAX_PATTERN)) begin
            len_eff = LEN_W'(MAX_PATTERN);
        end else begin
            len_eff = r_len;
        end

        n_win[0] = i_byte;
        for (int i = 1; i < MAX_PATTERN; i++) begin
            n_win[i] = r_win[i-1];
        end

        n_fill = (r_fill < FW'(MAX_PATTERN)) ? r_fill + FW'(1) : r_fill;

        // window entry i lines up with pattern byte len-1-i
        mism = 1'b0;
        for (int i = 0; i < MAX_PATTERN; i++) begin
            for (int k = 0; k < MAX_PATTERN; k++) begin
                if ((6'(i) + 6'(k) + 6'd1 == {1'b0, len_eff}) &&
                    (n_win[i] != pat[8*k +: 8])) begin
                    mism = 1'b1;
                end
            end
        end

        found = (6'(n_fill) >= 6'(len_eff)) && !mism;
        n_cnt = (found && (r_cnt != {CNT_W{1'b1}})) ? r_cnt + CNT_W'(1) : r_cnt;
        start = found ? r_pos - POS_W'(len_eff - LEN_W'(1)) : '0;
    end

    assign o_ready  = !i_q_full;
    assign accept   = i_valid && o_ready;
    assign o_push   = accept && (found || i_last);
    assign o_result = '{found: found, start: start, count: n_cnt, eot: i_last};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pat_lo <= '0;
            r_pat_hi <= '0;
            r_len    <= LEN_W'(1);
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_PAT_LO:  r_pat_lo <= i_cfg_data;
                CFG_PAT_HI:  r_pat_hi <= i_cfg_data;
                CFG_PAT_LEN: r_len    <= i_cfg_data[LEN_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill <= '0;
            r_pos  <= '0;
            r_cnt  <= '0;
        end else if (accept) begin
            if (i_last) begin
                r_fill <= '0;
                r_pos  <= '0;
                r_cnt  <= '0;
            end else begin
                r_fill <= n_fill;
                r_pos  <= r_pos + POS_W'(1);
                r_cnt  <= n_cnt;
            end
        end
    end

    // window contents are only compared once the fill count covers them
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_win <= n_win;
        end
    end

endmodule

// ===== hw/rtl/sms_queue.sv =====
// Two-entry result queue between the front end and the output stage.
module sms_queue (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  sms_pkg::t_result i_data,
    output logic             o_full,
    output logic             o_valid,
    input  logic             i_pop,
    output sms_pkg::t_result o_data
);
    import sms_pkg::*;

    t_result    r_mem [2];
    logic       r_wr;
    logic       r_rd;
    logic [1:0] r_cnt;

    assign o_full  = (r_cnt == 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign o_data  = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= 1'b0;
            r_rd  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_push) begin
                r_wr <= ~r_wr;
            end
            if (i_pop) begin
                r_rd <= ~r_rd;
            end
            r_cnt <= r_cnt + 2'(i_push) - 2'(i_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

endmodule

// ===== hw/rtl/sms_out.sv =====
// Output register stage driving the result stream.
module sms_out (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    input  sms_pkg::t_result i_data,
    output logic             o_pop,
    output logic             o_valid,
    input  logic             i_ready,
    output sms_pkg::t_result o_data
);
    import sms_pkg::*;

    logic    r_valid;
    t_result r_data;

    assign o_pop   = i_valid && (!r_valid || i_ready);
    assign o_valid = r_valid;
    assign o_data  = r_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_pop) begin
            r_valid <= 1'b1;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_data <= i_data;
        end
    end

endmodule

// ===== hw/rtl/sms_checker.sv =====
// Port-level assertions for the substring match stream core, with bind.
module sms_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [63:0] m_axis_tdata,
    input logic        m_axis_tuser,
    input logic        m_axis_tlast
);

    // a held result stays offered
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
        else $error("result dropped while stalled");

    // a transfer is either a match or the end of text
    a_reason: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tuser || m_axis_tlast))
        else $error("result with neither match nor end of text");

    // no match means a zero start position
    a_nostart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tuser |-> (m_axis_tdata[31:0] == 32'd0))
        else $error("start position set without a match");

    // a match always counts at least itself
    a_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser |-> (m_axis_tdata[63:32] != 32'd0))
        else $error("match reported with zero count");

endmodule

bind substring_match_stream_core sms_checker u_sms_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
);

// ===== test/tb_substring_match_stream_core.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for the streaming substring match core.
module tb_substring_match_stream_core;
    import sms_pkg::*;

    localparam int          WINDOW         = MAX_PATTERN_DEF;
    localparam int unsigned TEXT_TARGET    = 1200;
    localparam int unsigned SETTLE_CYCLES  = 8;
    localparam int unsigned WATCHDOG_LIMIT = 5000;

    logic                  i_clk         = 1'b0;
    logic                  i_rst_n       = 1'b0;
    logic                  i_cfg_valid   = 1'b0;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index   = CFG_PAT_LO;
    logic [CFG_DATA_W-1:0] i_cfg_data    = '0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [7:0]            s_axis_tdata  = '0;
    logic                  s_axis_tlast  = 1'b0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [63:0]           m_axis_tdata;
    logic                  m_axis_tuser;
    logic                  m_axis_tlast;

    substring_match_stream_core uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    always #10 i_clk = ~i_clk;

    // search state mirrored from the core
    logic [127:0] pattern     = '0;
    logic [4:0]   pattern_len = 5'd1;
    logic [7:0]   window [WINDOW];
    logic [31:0]  next_pos    = '0;
    int unsigned  fill        = 0;
    logic [31:0]  match_count = '0;

    t_result     expected_results [$];
    t_result     head_result;
    bit          calm_phase = 1'b0;
    int unsigned mismatches = 0;
    int unsigned bytes_sent = 0;
    int unsigned results_checked = 0;
    int unsigned matches_seen = 0;
    int unsigned texts_done = 0;
    int unsigned cfg_writes = 0;
    int unsigned idle_cycles = 0;

    initial begin
        foreach (window[k]) window[k] = '0;
    end

    function automatic int unsigned active_length();
        int unsigned len;
        len = pattern_len;
        if (len == 0) len = 1;
        if (len > WINDOW) len = WINDOW;
        return len;
    endfunction

    // Shifts one byte into the window; returns 1 when the byte yields a result.
    function automatic bit step_search(input logic [7:0] b, input logic last,
                                       output t_result r);
        int unsigned len;
        int          k;
        bit          hit;
        logic [31:0] here;
        len = active_length();
        for (k = WINDOW - 1; k > 0; k--) window[k] = window[k-1];
        window[0] = b;
        if (fill < WINDOW) fill++;
        hit = (fill >= len);
        for (k = 0; k < int'(len); k++)
            if (pattern[8*k +: 8] != window[len-1-k]) hit = 1'b0;
        here = next_pos;
        r.start = hit ? here - 32'(len - 1) : '0;
        if (hit && match_count != '1) match_count++;
        next_pos = here + 1;
        r.found = hit;
        r.count = match_count;
        r.eot   = last;
        if (last) begin
            foreach (window[j]) window[j] = '0;
            next_pos    = '0;
            fill        = 0;
            match_count = '0;
        end
        return hit || last;
    endfunction

    function automatic int unsigned pick_gap();
        int unsigned r;
        if (calm_phase) return 0;
        r = $urandom_range(0, 99);
        if (r < 50) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    task automatic note_error(input string msg);
        mismatches++;
        if (mismatches <= 10) $display("%s", msg);
    endtask

    task automatic send_text_byte(input logic [7:0] b, input logic last);
        int unsigned gap;
        t_result     r;
        @(negedge i_clk);
        gap = pick_gap();
        if (gap != 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        s_axis_tlast  <= last;
        do @(posedge i_clk); while (!s_axis_tready);
        bytes_sent++;
        if (last) texts_done++;
        if (step_search(b, last, r)) expected_results = {expected_results, r};
    endtask

    // sender holds off until every pending result is out and the pipe is empty
    task automatic settle_core();
        @(negedge i_clk);
        s_axis_tvalid <= 1'b0;
        while (expected_results.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input t_cfg_idx idx, input logic [63:0] value);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (idx)
            CFG_PAT_LO:  pattern[63:0]   = value;
            CFG_PAT_HI:  pattern[127:64] = value;
            CFG_PAT_LEN: pattern_len     = value[4:0];
            default: ;
        endcase
        cfg_writes++;
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    // reset values: zero pattern of length one, then a final byte with no match
    task automatic test_reset_state();
        send_text_byte(8'h00, 1'b0);
        send_text_byte(8'h5A, 1'b1);
    endtask

    // length zero acts as one, oversized length acts as the full window
    task automatic test_length_limits();
        int k;
        settle_core();
        write_reg(CFG_PAT_LEN, 64'd0);
        write_reg(CFG_PAT_LO, 64'h0000_0000_0000_00FF);
        send_text_byte(8'hFF, 1'b1);
        settle_core();
        write_reg(CFG_PAT_LO, 64'h00FF_00FF_00FF_00FF);
        write_reg(CFG_PAT_HI, 64'h00FF_00FF_00FF_00FF);
        write_reg(CFG_PAT_LEN, 64'd31);
        for (k = 0; k < WINDOW; k++) send_text_byte(pattern[8*k +: 8], k == WINDOW - 1);
    endtask

    // overlapping hits, then a longer pattern applied to bytes already held
    task automatic test_overlap_and_retune();
        settle_core();
        write_reg(CFG_PAT_LO, 64'h0000_0000_00AA_AAAA);
        write_reg(CFG_PAT_LEN, 64'd2);
        repeat (3) send_text_byte(8'hAA, 1'b0);
        settle_core();
        write_reg(CFG_PAT_LEN, 64'd3);
        send_text_byte(8'hAA, 1'b1);
    endtask

    task automatic test_random_texts();
        logic [7:0]   letters [2];
        logic [7:0]   chunk [$];
        logic [127:0] pat_new;
        logic [4:0]   len_new;
        int unsigned  r, k, m, plen, tlen, n_texts;
        bit           ended;
        while (bytes_sent < TEXT_TARGET) begin
            settle_core();
            calm_phase = ($urandom_range(0, 4) == 0);
            letters[0] = 8'($urandom_range(0, 255));
            letters[1] = ($urandom_range(0, 3) == 0) ? letters[0] ^ 8'h01
                                                     : 8'($urandom_range(0, 255));
            r = $urandom_range(0, 9);
            if (r == 0)      len_new = 5'd1;
            else if (r == 1) len_new = 5'd16;
            else if (r == 2) len_new = $urandom_range(0, 1) ? 5'd0 : 5'($urandom_range(17, 31));
            else             len_new = 5'($urandom_range(1, 16));
            for (k = 0; k < 16; k++)
                pat_new[8*k +: 8] = ($urandom_range(0, 4) == 0) ? 8'($urandom_range(0, 255))
                                                                : letters[$urandom_range(0, 1)];
            if ($urandom_range(0, 3) != 0) write_reg(CFG_PAT_LO, pat_new[63:0]);
            if ($urandom_range(0, 3) != 0) write_reg(CFG_PAT_HI, pat_new[127:64]);
            write_reg(CFG_PAT_LEN, 64'(len_new));
            n_texts = $urandom_range(2, 6);
            repeat (n_texts) begin
                chunk.delete();
                tlen = ($urandom_range(0, 4) != 0) ? $urandom_range(1, 40)
                                                   : $urandom_range(41, 120);
                plen = active_length();
                while (chunk.size() < tlen) begin
                    r = $urandom_range(0, 99);
                    if (r < 40) begin
                        for (k = 0; k < plen; k++) chunk = {chunk, pattern[8*k +: 8]};
                    end else if (r < 55) begin
                        // broken copy: a prefix, then a corrupted byte
                        m = $urandom_range(0, plen - 1);
                        for (k = 0; k < m; k++) chunk = {chunk, pattern[8*k +: 8]};
                        chunk = {chunk, pattern[8*m +: 8] ^ (8'h01 << $urandom_range(0, 7))};
                    end else if (r < 90) begin
                        chunk = {chunk, letters[$urandom_range(0, 1)]};
                    end else begin
                        chunk = {chunk, 8'($urandom_range(0, 255))};
                    end
                end
                ended = ($urandom_range(0, 9) != 0);
                foreach (chunk[i]) send_text_byte(chunk[i], ended && i == chunk.size() - 1);
                if ($urandom_range(0, 19) == 0) settle_core();
            end
        end
        calm_phase = 1'b0;
    endtask

    // result side: random back-pressure
    initial begin
        int unsigned n;
        while (!i_rst_n) @(negedge i_clk);
        forever begin
            n = pick_gap();
            repeat (n) begin
                @(negedge i_clk);
                m_axis_tready <= 1'b0;
            end
            n = $urandom_range(1, 24);
            repeat (n) begin
                @(negedge i_clk);
                m_axis_tready <= 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (expected_results.size() == 0) begin
                note_error($sformatf("unexpected result: found=%b start=%0d count=%0d eot=%b",
                                     m_axis_tuser, m_axis_tdata[31:0], m_axis_tdata[63:32],
                                     m_axis_tlast));
            end else begin
                head_result = expected_results.pop_front();
                results_checked++;
                if (m_axis_tuser) matches_seen++;
                if (m_axis_tuser !== head_result.found || m_axis_tdata[31:0] !== head_result.start
                    || m_axis_tdata[63:32] !== head_result.count
                    || m_axis_tlast !== head_result.eot)
                    note_error($sformatf({"result %0d: expected found=%b start=%0d count=%0d ",
                                          "eot=%b, got found=%b start=%0d count=%0d eot=%b"},
                                         results_checked, head_result.found, head_result.start,
                                         head_result.count, head_result.eot, m_axis_tuser,
                                         m_axis_tdata[31:0], m_axis_tdata[63:32], m_axis_tlast));
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
            || (i_cfg_valid && o_cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog: no transfer for %0d cycles", idle_cycles);
            $display("FAIL substring_match_stream_core");
            $finish;
        end
    end

    initial begin
        repeat (8) @(negedge i_clk);
        i_rst_n <= 1'b1;
        test_reset_state();
        test_length_limits();
        test_overlap_and_retune();
        test_random_texts();
        settle_core();
        if (expected_results.size() != 0)
            note_error($sformatf("%0d results never arrived", expected_results.size()));
        $display("Sent %0d text bytes in %0d terminated texts over %0d register writes;",
                 bytes_sent, texts_done, cfg_writes);
        $display("checked %0d results, %0d of them matches, %0d mismatches.",
                 results_checked, matches_seen, mismatches);
        if (mismatches == 0)
            $display("PASS substring_match_stream_core");
        else
            $display("FAIL substring_match_stream_core");
        $finish;
    end

endmodule
